// ===== rtl/rstab_pkg.sv =====
`default_nettype none

package rstab_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  // operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_ENUM   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] value_in;
    logic [5:0]  target_slot;
  } rstab_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_id;
    logic [31:0] value_out;
    logic        last;
  } rstab_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // register the accepted item
    logic exec_load;  // run add/remove/empty enumerate, load result register
    logic scan_load;  // load enumerate scan vector
    logic enum_rd;    // pick next occupied slot, read its value
    logic enum_ld;    // load enumerate result register
  } rstab_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] operation;
    logic       enum_empty;
    logic       scan_last;
  } rstab_sts_t;

endpackage

`default_nettype wire

// ===== rtl/rstab_ctrl.sv =====
`default_nettype none

module rstab_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  input  rstab_pkg::rstab_sts_t  sts_i,
  output rstab_pkg::rstab_cmd_t  cmd_o
);
  import rstab_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ENUM_RD,
    S_ENUM_LD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.operation == OP_ENUM && !sts_i.enum_empty) begin
          cmd_o.scan_load = 1'b1;
          state_d         = S_ENUM_RD;
        end else if (sts_i.operation != OP_ADD && sts_i.operation != OP_REMOVE &&
                     sts_i.operation != OP_ENUM) begin
          // unused code, no result
          state_d = S_IDLE;
        end else if (out_free) begin
          cmd_o.exec_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_ENUM_RD: begin
        cmd_o.enum_rd = 1'b1;
        state_d       = S_ENUM_LD;
      end
      S_ENUM_LD: begin
        if (out_free) begin
          cmd_o.enum_ld = 1'b1;
          state_d       = sts_i.scan_last ? S_IDLE : S_ENUM_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.exec_load || cmd_o.enum_ld) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/rstab_dpath.sv =====
`default_nettype none

module rstab_dpath #(
  parameter int SLOTS      = rstab_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = rstab_pkg::VALUE_BITS_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  rstab_pkg::rstab_in_t   in_data_i,
  output rstab_pkg::rstab_out_t  out_data_o,
  input  rstab_pkg::rstab_cmd_t  cmd_i,
  output rstab_pkg::rstab_sts_t  sts_o
);
  import rstab_pkg::*;

  localparam int IDW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HWW = $clog2(SLOTS + 1);

  logic [VALUE_BITS-1:0] mem [SLOTS];
  logic [VALUE_BITS-1:0] rdata_q;

  rstab_in_t  item_q;
  rstab_out_t out_q;

  logic [HWW-1:0]   hw_q;
  logic [SLOTS-1:0] occ_q;   // slot holds a nonzero value, meaningful below the mark
  logic [SLOTS-1:0] scan_q;
  logic [IDW-1:0]   enum_slot_q;
  logic             enum_last_q;

  logic [SLOTS-1:0]      below;
  logic [SLOTS-1:0]      free_vec;
  logic [SLOTS-1:0]      live_vec;
  logic [SLOTS-1:0]      scan_next;
  logic [IDW-1:0]        free_idx;
  logic [IDW-1:0]        scan_idx;
  logic [IDW-1:0]        add_idx;
  logic [IDW-1:0]        tgt_idx;
  logic                  free_found;
  logic                  table_full;
  logic                  tgt_in_range;
  logic [VALUE_BITS-1:0] val_masked;
  logic                  add_we;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      below[i] = (32'(i) < 32'(hw_q));
    end
  end

  assign free_vec = ~occ_q & below;
  assign live_vec = occ_q & below;

  // lowest empty slot below the mark
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) free_idx = IDW'(i);
    end
  end

  // lowest occupied slot still to report
  always_comb begin
    scan_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (scan_q[i]) scan_idx = IDW'(i);
    end
  end

  always_comb begin
    scan_next           = scan_q;
    scan_next[scan_idx] = 1'b0;
  end

  assign free_found   = |free_vec;
  assign table_full   = !free_found && (hw_q == HWW'(SLOTS));
  assign add_idx      = free_found ? free_idx : IDW'(hw_q);
  assign tgt_in_range = (32'(item_q.target_slot) < 32'(hw_q));
  assign tgt_idx      = IDW'(item_q.target_slot);
  assign val_masked   = VALUE_BITS'(item_q.value_in);
  assign add_we       = cmd_i.exec_load && item_q.operation == OP_ADD && !table_full;

  // value store, registered read
  always_ff @(posedge clk_i) begin
    if (add_we) mem[add_idx] <= val_masked;
    if (cmd_i.enum_rd) rdata_q <= mem[scan_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= '0;
    end else if (add_we && !free_found) begin
      hw_q <= hw_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;

    if (add_we) begin
      occ_q[add_idx] <= (val_masked != '0);
    end else if (cmd_i.exec_load && item_q.operation == OP_REMOVE && tgt_in_range) begin
      occ_q[tgt_idx] <= 1'b0;
    end

    if (cmd_i.scan_load) begin
      scan_q <= live_vec;
    end else if (cmd_i.enum_rd) begin
      scan_q <= scan_next;
    end

    if (cmd_i.enum_rd) begin
      enum_slot_q <= scan_idx;
      enum_last_q <= (scan_next == '0);
    end

    if (cmd_i.exec_load) begin
      out_q.value_out <= '0;
      out_q.last      <= 1'b1;
      case (item_q.operation)
        OP_ADD: begin
          out_q.status  <= table_full ? ST_FULL : ST_OK;
          out_q.slot_id <= table_full ? 6'd0 : 6'(add_idx);
        end
        OP_REMOVE: begin
          out_q.status  <= tgt_in_range ? ST_OK : ST_RANGE;
          out_q.slot_id <= item_q.target_slot;
        end
        default: begin
          out_q.status  <= ST_NONE;
          out_q.slot_id <= 6'd0;
        end
      endcase
    end else if (cmd_i.enum_ld) begin
      out_q.status    <= ST_OK;
      out_q.slot_id   <= 6'(enum_slot_q);
      out_q.value_out <= 32'(rdata_q);
      out_q.last      <= enum_last_q;
    end
  end

  assign out_data_o       = out_q;
  assign sts_o.operation  = item_q.operation;
  assign sts_o.enum_empty = (live_vec == '0);
  assign sts_o.scan_last  = enum_last_q;

endmodule

`default_nettype wire

// ===== rtl/reusable_slot_table_top.sv =====
`default_nettype none

// slot table with a high-water mark. add stores value_in in the lowest empty
// slot (one holding zero) below the mark, or else at the mark, which then
// advances; the result carries the slot number, or status full when no slot
// is left. remove clears a slot below the mark and flags anything at or
// above it as out of range. enumerate reports each occupied slot below the
// mark in ascending order with its value, last set on the final one, or a
// single nothing-occupied result. every item except the unused operation
// code gets results; the unused code gives none. add and remove are
// accepted, then executed against the occupancy vector and its first-empty
// priority encoder. enumerate is accepted, loads its scan vector, then for
// each reported slot does a registered read of the value memory and loads
// the result register. the result register lets the next item be accepted
// while the last result of the previous one still waits. no clearing pass
// after reset: the mark alone decides which slots are live.
module reusable_slot_table_top #(
  parameter int SLOTS      = rstab_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = rstab_pkg::VALUE_BITS_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // input item channel
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  rstab_pkg::rstab_in_t   in_data_i,
  // result item channel
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output rstab_pkg::rstab_out_t  out_data_o
);
  import rstab_pkg::*;

  rstab_cmd_t cmd;
  rstab_sts_t sts;

  // sequencer: accept, execute, enumerate walk, result handshake
  rstab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // value memory, occupancy vector, mark and result register
  rstab_dpath #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire

// ===== dv/tb_reusable_slot_table_top.sv =====
`default_nettype none

module tb_reusable_slot_table_top;
  import rstab_pkg::*;

  // the package has no name for the fourth operation code
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         N_SLOTS     = SLOTS_DEF;
  localparam int         RAND_ITEMS  = 310;
  localparam int         CYCLE_LIMIT = 4000000;
  localparam int         HOLD_CYCLES = 400;

  // one row of the directed stimulus; res is only used when typed is set
  typedef struct packed {
    rstab_in_t  item;
    logic       typed;
    rstab_out_t res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  rstab_in_t  in_data;
  logic       out_valid;
  logic       out_stall;
  rstab_out_t out_data;

  // predictor state: slot contents and the high-water mark
  logic [31:0] slot_vals [0:N_SLOTS-1];
  int          mark;

  rstab_out_t  step_res [$];   // results of the item just predicted
  rstab_out_t  awaited [$];    // results still owed by the block, oldest first
  dir_row_t    rows [$];
  rstab_out_t  head_res;
  int          err_cnt      = 0;
  int          results_seen = 0;
  int          cycle_cnt    = 0;
  int          calm_left    = 0;

  reusable_slot_table_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #6 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_reusable_slot_table_top: errors");
      $finish;
    end
  end

  function automatic rstab_out_t mk_res(logic [1:0] st, int id, logic [31:0] v, logic lst);
    rstab_out_t r;
    r.status    = st;
    r.slot_id   = id[5:0];
    r.value_out = v;
    r.last      = lst;
    return r;
  endfunction

  function automatic rstab_in_t mk_item(logic [1:0] op, logic [31:0] v, logic [5:0] t);
    rstab_in_t it;
    it.operation   = op;
    it.value_in    = v;
    it.target_slot = t;
    return it;
  endfunction

  // advance the predictor by one accepted item, results land in step_res
  function void slots_step(rstab_in_t it);
    int i;
    int found;
    int final_idx;
    step_res.delete();
    case (it.operation)
      OP_ADD: begin
        // first empty slot below the mark wins over an append
        found = -1;
        for (i = 0; i < mark; i++)
          if (found < 0 && slot_vals[i] == 32'd0) found = i;
        if (found >= 0) begin
          slot_vals[found] = it.value_in;
          step_res.push_back(mk_res(ST_OK, found, 32'd0, 1'b1));
        end else if (mark >= N_SLOTS) begin
          step_res.push_back(mk_res(ST_FULL, 0, 32'd0, 1'b1));
        end else begin
          // a zero value still moves the mark
          slot_vals[mark] = it.value_in;
          step_res.push_back(mk_res(ST_OK, mark, 32'd0, 1'b1));
          mark++;
        end
      end
      OP_REMOVE: begin
        if (int'(it.target_slot) < mark) begin
          slot_vals[it.target_slot] = 32'd0;
          step_res.push_back(mk_res(ST_OK, int'(it.target_slot), 32'd0, 1'b1));
        end else begin
          step_res.push_back(mk_res(ST_RANGE, int'(it.target_slot), 32'd0, 1'b1));
        end
      end
      OP_ENUM: begin
        final_idx = -1;
        for (i = 0; i < mark; i++)
          if (slot_vals[i] != 32'd0) final_idx = i;
        if (final_idx < 0) begin
          step_res.push_back(mk_res(ST_NONE, 0, 32'd0, 1'b1));
        end else begin
          for (i = 0; i <= final_idx; i++)
            if (slot_vals[i] != 32'd0)
              step_res.push_back(mk_res(ST_OK, i, slot_vals[i], i == final_idx));
        end
      end
      default: ;  // unused code: no state change, no result
    endcase
  endfunction

  // no empty slot below the mark and the mark at the top
  function automatic bit table_full();
    int i;
    if (mark < N_SLOTS) return 1'b0;
    for (i = 0; i < N_SLOTS; i++)
      if (slot_vals[i] == 32'd0) return 1'b0;
    return 1'b1;
  endfunction

  // mostly back to back, some short gaps, a few long ones, plus calm stretches
  function int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 30);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random payload with the all-zero and all-one corners weighted in
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function void add_row(logic [1:0] op, logic [31:0] v, logic [5:0] t, logic typed,
                        logic [1:0] st, int id);
    dir_row_t row;
    row.item  = mk_item(op, v, t);
    row.typed = typed;
    row.res   = mk_res(st, id, 32'd0, 1'b1);
    rows.push_back(row);
  endfunction

  // offer one item from a falling edge, hold it until taken, then predict.
  // returns at the falling edge after acceptance with valid still high
  task automatic send_item(rstab_in_t it, logic typed, rstab_out_t typed_res);
    int gap;
    int k;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    slots_step(it);
    if (typed) begin
      awaited.push_back(typed_res);
    end else begin
      for (k = 0; k < step_res.size(); k++) awaited.push_back(step_res[k]);
    end
    @(negedge clk);
  endtask

  // result checker: every taken item is matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (awaited.size() == 0) begin
        $error("result with nothing expected: status %0d slot %0d value %h last %0d",
               out_data.status, out_data.slot_id, out_data.value_out, out_data.last);
        err_cnt++;
      end else begin
        head_res = awaited.pop_front();
        if (out_data.status !== head_res.status) begin
          $error("status: expected %0d, got %0d", head_res.status, out_data.status);
          err_cnt++;
        end
        if (out_data.slot_id !== head_res.slot_id) begin
          $error("slot_id: expected %0d, got %0d", head_res.slot_id, out_data.slot_id);
          err_cnt++;
        end
        if (out_data.value_out !== head_res.value_out) begin
          $error("value_out: expected %h, got %h", head_res.value_out, out_data.value_out);
          err_cnt++;
        end
        if (out_data.last !== head_res.last) begin
          $error("last: expected %0d, got %0d", head_res.last, out_data.last);
          err_cnt++;
        end
      end
    end
  end

  // result side: random stall bursts, and one long hold-off once traffic is
  // flowing so the result path backs up into the input stall
  initial begin : result_stall
    int free_len;
    int stall_len;
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!held && results_seen >= 80) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else begin
        out_stall <= 1'b0;
        // sometimes a long stretch with no stall at all
        free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 4);
        repeat (free_len) @(negedge clk);
        case ($urandom_range(0, 9))
          0, 1, 2: stall_len = 0;
          9:       stall_len = $urandom_range(10, 40);
          default: stall_len = $urandom_range(1, 3);
        endcase
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(negedge clk);
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int         n_items;
    int         r;
    int         idx;
    bit         filled;
    logic [1:0] op;
    logic [5:0] tgt;
    logic [31:0] v;
    rstab_in_t  it;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    mark     = 0;

    // directed rows: empty table first, then the corners of each operation
    add_row(OP_ENUM,   32'd0,        6'd0,  1'b1, ST_NONE,  0);   // nothing occupied
    add_row(OP_REMOVE, 32'd0,        6'd0,  1'b1, ST_RANGE, 0);   // empty table
    add_row(OP_REMOVE, 32'hFFFF_FFFF, 6'd63, 1'b1, ST_RANGE, 63);
    add_row(OP_ADD,    32'hFFFF_FFFF, 6'd63, 1'b1, ST_OK,    0);
    add_row(OP_ADD,    32'd0,        6'd0,  1'b1, ST_OK,    1);   // zero still appends
    add_row(OP_ENUM,   32'd0,        6'd0,  1'b0, ST_OK,    0);
    add_row(OP_ADD,    32'h0000_0001, 6'd0,  1'b1, ST_OK,    1);   // reuses the zero slot
    add_row(OP_ADD,    32'h8000_0000, 6'd21, 1'b0, ST_OK,    0);
    add_row(OP_ENUM,   32'hFFFF_FFFF, 6'd63, 1'b0, ST_OK,    0);
    add_row(OP_REMOVE, 32'd0,        6'd0,  1'b1, ST_OK,    0);   // slot zero
    add_row(OP_REMOVE, 32'd0,        6'd0,  1'b1, ST_OK,    0);   // already empty
    add_row(OP_REMOVE, 32'd0,        6'd3,  1'b1, ST_RANGE, 3);   // right at the mark
    add_row(OP_UNUSED, 32'hFFFF_FFFF, 6'd63, 1'b0, ST_OK,    0);   // no result
    add_row(OP_ADD,    32'h5A5A_5A5A, 6'd42, 1'b0, ST_OK,    0);
    add_row(OP_REMOVE, 32'd0,        6'd2,  1'b1, ST_OK,    2);
    add_row(OP_ENUM,   32'd0,        6'd0,  1'b0, ST_OK,    0);
    add_row(OP_ADD,    32'hA5A5_A5A5, 6'd0,  1'b0, ST_OK,    0);
    add_row(OP_REMOVE, 32'd0,        6'd1,  1'b1, ST_OK,    1);
    add_row(OP_REMOVE, 32'd0,        6'd2,  1'b1, ST_OK,    2);
    add_row(OP_REMOVE, 32'd0,        6'd0,  1'b1, ST_OK,    0);
    add_row(OP_ENUM,   32'd0,        6'd0,  1'b1, ST_NONE,  0);   // all cleared below the mark
    add_row(OP_REMOVE, 32'd0,        6'd42, 1'b1, ST_RANGE, 42);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (idx = 0; idx < rows.size(); idx++)
      send_item(rows[idx].item, rows[idx].typed, rows[idx].res);

    // random part: mixed traffic, with one fill run to the top partway in so
    // the full case and long enumerations keep coming afterwards
    n_items = 0;
    filled  = 1'b0;
    while (n_items < RAND_ITEMS) begin
      if (!filled && n_items >= 100) begin
        while (!table_full()) begin
          do v = $urandom; while (v == 32'd0);
          send_item(mk_item(OP_ADD, v, 6'($urandom_range(0, 63))), 1'b0, '0);
          n_items++;
        end
        repeat (2) begin
          send_item(mk_item(OP_ADD, pick_value(), 6'($urandom_range(0, 63))), 1'b0, '0);
          n_items++;
        end
        send_item(mk_item(OP_ENUM, $urandom, 6'($urandom_range(0, 63))), 1'b0, '0);
        n_items++;
        filled = 1'b1;
      end else begin
        r   = $urandom_range(0, 99);
        tgt = 6'($urandom_range(0, 63));
        if (r < 45) begin
          op = OP_ADD;
        end else if (r < 75) begin
          op = OP_REMOVE;
          // mostly aim at live slots, sometimes anywhere
          if (mark > 0 && $urandom_range(0, 9) < 7) tgt = 6'($urandom_range(0, mark - 1));
        end else if (r < 93) begin
          op = OP_ENUM;
        end else begin
          op = OP_UNUSED;
        end
        it = mk_item(op, pick_value(), tgt);
        send_item(it, 1'b0, '0);
        if (op != OP_UNUSED) n_items++;
      end
    end

    in_valid <= 1'b0;

    // drain, then a short quiet window to catch stray results
    while (awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb_reusable_slot_table_top: clean");
    end else begin
      $display("tb_reusable_slot_table_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
